/* src/i8mvz_pkg.sv */
// shared types and constants for the int8 matrix-vector zero point core
package i8mvz_pkg;

   // request command codes
   typedef enum logic [0:0] {
      CMD_LOAD_VECTOR   = 1'b0,
      CMD_MATRIX_ELEMENT = 1'b1
   } cmd_type;

   // register indexes on the csr write port
   localparam logic [1:0] CSR_ZERO_POINT  = 2'd0;
   localparam logic [1:0] CSR_COLS_IN_USE = 2'd1;
   localparam logic [1:0] CSR_ROWS_IN_USE = 2'd2;

   // field widths
   localparam int ElemWidth  = 8;
   localparam int IndexWidth = 10;
   localparam int ColsWidth  = 11;
   localparam int RowsWidth  = 16;
   localparam int SumWidth   = 32;
   localparam int CsrWidth   = 16;

   // register reset values
   localparam logic [ColsWidth-1:0] ColsReset = 11'd1024;
   localparam logic [RowsWidth-1:0] RowsReset = 16'd1;

endpackage

/* src/i8mvz_ram.sv */
// generic single write port, single read port ram with registered read
module i8mvz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/int8_matrix_vector_zero_point_core.sv */
// int8 matrix-vector multiply with zero point, top level
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | command, element, element_index
//   rsp     | out       | rsp_valid / rsp_ready  | row_sum, row_index, last_row
//   csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
// one request per cycle while req_ready is high; a row sum leaves after its last element
// through the vector ram read, then the multiply-accumulate into the output register.
// column and row counters advance when a request is taken, at the same edge as the
// vector ram read is registered; the accumulate then works from the stage registers.
// reset clears counters, accumulator and valids; the vector ram is not cleared.
// a waiting result stalls requests only when the accumulate stage also ends a row.
module int8_matrix_vector_zero_point_core #(
   parameter int MAX_COLS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_command,
   input  logic signed [i8mvz_pkg::ElemWidth-1:0] req_element,
   input  logic [i8mvz_pkg::IndexWidth-1:0]      req_element_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [i8mvz_pkg::SumWidth-1:0] rsp_row_sum,
   output logic [i8mvz_pkg::RowsWidth-1:0]       rsp_row_index,
   output logic                                  rsp_last_row,
   input  logic                                  csr_write_enable,
   input  logic [1:0]                            csr_index,
   input  logic [i8mvz_pkg::CsrWidth-1:0]        csr_write_data
);

   localparam int AW = $clog2(MAX_COLS);
   localparam int CW = i8mvz_pkg::ColsWidth;
   localparam int RW = i8mvz_pkg::RowsWidth;
   localparam int EW = i8mvz_pkg::ElemWidth;
   localparam int SW = i8mvz_pkg::SumWidth;

   // configuration registers
   logic [EW-1:0] zero_point_ff;
   logic [CW-1:0] cols_in_use_ff;
   logic [RW-1:0] rows_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_point_ff  <= '0;
         cols_in_use_ff <= i8mvz_pkg::ColsReset;
         rows_in_use_ff <= i8mvz_pkg::RowsReset;
      end else if (csr_write_enable) begin
         if (csr_index == i8mvz_pkg::CSR_ZERO_POINT) begin
            zero_point_ff <= csr_write_data[EW-1:0];
         end
         if (csr_index == i8mvz_pkg::CSR_COLS_IN_USE) begin
            cols_in_use_ff <= csr_write_data[CW-1:0];
         end
         if (csr_index == i8mvz_pkg::CSR_ROWS_IN_USE) begin
            rows_in_use_ff <= csr_write_data[RW-1:0];
         end
      end
   end

   // effective limits
   logic [CW-1:0] eff_cols;
   logic [RW-1:0] eff_rows;

   always_comb begin
      eff_cols = cols_in_use_ff;
      if (cols_in_use_ff == '0) begin
         eff_cols = CW'(1);
      end else if (32'(cols_in_use_ff) > MAX_COLS) begin
         eff_cols = CW'(MAX_COLS);
      end
      eff_rows = (rows_in_use_ff == '0) ? RW'(1) : rows_in_use_ff;
   end

   // request side counters
   logic [CW-1:0] column_count_ff, column_count_in;
   logic [RW-1:0] row_count_ff, row_count_in;

   // accumulate stage registers
   logic                  s1_valid_ff, s1_valid_in;
   i8mvz_pkg::cmd_type    s1_cmd_ff;
   logic signed [EW-1:0]  s1_element_ff;
   logic                  s1_row_end_ff;
   logic [RW-1:0]         s1_row_index_ff;
   logic                  s1_last_ff;

   // accumulator and output register
   logic [SW-1:0] acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_row_sum_ff;
   logic [RW-1:0] rsp_row_index_ff;
   logic          rsp_last_row_ff;

   logic               req_take;
   logic               s1_free;
   logic               s1_consume;
   i8mvz_pkg::cmd_type req_cmd;
   logic [CW-1:0]      col;
   logic               col_last;
   logic               row_last;

   // ram ports
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   assign req_cmd = i8mvz_pkg::cmd_type'(req_command);

   // accumulate stage may move unless it ends a row and the output is full
   assign s1_free    = !s1_valid_ff || !s1_row_end_ff || !rsp_valid_ff || rsp_ready;
   assign s1_consume = s1_valid_ff && s1_free;
   assign req_ready  = s1_free;
   assign req_take   = req_valid && req_ready;

   // column position and row end for the incoming matrix element
   always_comb begin
      col      = (column_count_ff >= eff_cols) ? (eff_cols - CW'(1)) : column_count_ff;
      col_last = (col == (eff_cols - CW'(1)));
      row_last = ({1'b0, row_count_ff} + 17'd1) >= {1'b0, eff_rows};
   end

   // counter update
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (req_take) begin
         unique case (req_cmd)
            i8mvz_pkg::CMD_LOAD_VECTOR: begin
               column_count_in = '0;
               row_count_in    = '0;
            end
            i8mvz_pkg::CMD_MATRIX_ELEMENT: begin
               if (!col_last) begin
                  column_count_in = col + CW'(1);
               end else begin
                  column_count_in = '0;
                  row_count_in    = row_last ? '0 : (row_count_ff + RW'(1));
               end
            end
            default: begin
               column_count_in = column_count_ff;
               row_count_in    = row_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // vector ram access
   assign ram_wr_en   = req_take && (req_cmd == i8mvz_pkg::CMD_LOAD_VECTOR)
                        && (32'(req_element_index) < MAX_COLS);
   assign ram_wr_addr = AW'(req_element_index);
   assign ram_rd_en   = req_take && (req_cmd == i8mvz_pkg::CMD_MATRIX_ELEMENT);
   assign ram_rd_addr = AW'(col);

   i8mvz_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_COLS)
   ) u_vector_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_element),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // accumulate stage valid
   assign s1_valid_in = req_take ? 1'b1 : (s1_consume ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // accumulate stage payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff       <= req_cmd;
         s1_element_ff   <= req_element;
         s1_row_end_ff   <= (req_cmd == i8mvz_pkg::CMD_MATRIX_ELEMENT) && col_last;
         s1_row_index_ff <= row_count_ff;
         s1_last_ff      <= row_last;
      end
   end

   // multiply by vector entry minus zero point
   logic signed [EW:0]   diff;
   logic signed [2*EW:0] prod;
   logic [SW-1:0]        sum;

   always_comb begin
      diff = $signed({ram_rd_data[EW-1], ram_rd_data})
             - $signed({zero_point_ff[EW-1], zero_point_ff});
      prod = s1_element_ff * diff;
      sum  = acc_ff + SW'(prod);
   end

   // accumulator update
   always_comb begin
      acc_in = acc_ff;
      if (s1_consume) begin
         unique case (s1_cmd_ff)
            i8mvz_pkg::CMD_LOAD_VECTOR:    acc_in = '0;
            i8mvz_pkg::CMD_MATRIX_ELEMENT: acc_in = s1_row_end_ff ? '0 : sum;
            default:                       acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // output register
   assign rsp_valid_in = (s1_consume && s1_row_end_ff) ? 1'b1
                         : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_consume && s1_row_end_ff) begin
         rsp_row_sum_ff   <= sum;
         rsp_row_index_ff <= s1_row_index_ff;
         rsp_last_row_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_sum   = $signed(rsp_row_sum_ff);
   assign rsp_row_index = rsp_row_index_ff;
   assign rsp_last_row  = rsp_last_row_ff;

`ifndef SYNTH
   // requests stall only when the accumulate stage holds a row end and the output is full
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_row_end_ff && rsp_valid_ff))
      else $error("request stalled without a full pipeline");

   // a taken matrix element reaches the accumulate stage
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_cmd == i8mvz_pkg::CMD_MATRIX_ELEMENT) |=> s1_valid_ff)
      else $error("matrix element lost before accumulate");

   // ram read data holds while the accumulate stage is held
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_free) |=> $stable(ram_rd_data))
      else $error("vector data changed under a stalled element");

   // the final row leaves the row counter at zero
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_row_end_ff && s1_last_ff) |-> (row_count_ff == '0))
      else $error("row counter not cleared after final row");
`endif

endmodule

/* tb/sv/int8_matrix_vector_zero_point_core_test.sv */
// self-checking testbench for the int8 matrix-vector zero point core
module int8_matrix_vector_zero_point_core_test;

   localparam int MaxCols      = 1024;
   localparam int SettleCycles = 4;
   localparam int SegmentItems = 45;

   typedef struct {
      logic signed [i8mvz_pkg::SumWidth-1:0] row_sum;
      logic [i8mvz_pkg::RowsWidth-1:0]       row_index;
      logic                                  last_row;
   } row_result_type;

   // predicts row sums from accepted requests and checks them in order
   class row_sum_book;
      logic signed [i8mvz_pkg::ElemWidth-1:0] vector_copy [MaxCols];
      bit                                     loaded [MaxCols];
      logic signed [i8mvz_pkg::ElemWidth-1:0] zero_point = '0;
      logic [i8mvz_pkg::ColsWidth-1:0]        cols_in_use = i8mvz_pkg::ColsReset;
      logic [i8mvz_pkg::RowsWidth-1:0]        rows_in_use = i8mvz_pkg::RowsReset;
      logic [i8mvz_pkg::ColsWidth-1:0]        column_count = '0;
      logic [i8mvz_pkg::RowsWidth-1:0]        row_count = '0;
      logic signed [i8mvz_pkg::SumWidth-1:0]  accumulator = '0;
      row_result_type                         expected_rows [$];
      int errors;
      int requests;
      int loads;
      int results;
      int last_rows;

      function void write_register(logic [1:0] index,
                                   logic [i8mvz_pkg::CsrWidth-1:0] data);
         case (index)
            i8mvz_pkg::CSR_ZERO_POINT:  zero_point = data[i8mvz_pkg::ElemWidth-1:0];
            i8mvz_pkg::CSR_COLS_IN_USE: cols_in_use = data[i8mvz_pkg::ColsWidth-1:0];
            i8mvz_pkg::CSR_ROWS_IN_USE: rows_in_use = data[i8mvz_pkg::RowsWidth-1:0];
            default: ;
         endcase
      endfunction

      // zero acts as one, anything past the store acts as the store size
      function int effective_cols();
         if (cols_in_use == 0) return 1;
         if (cols_in_use > MaxCols) return MaxCols;
         return int'(cols_in_use);
      endfunction

      // column that the next matrix element reads, clamped when past the limit
      function int next_column();
         int eff;
         eff = effective_cols();
         return (int'(column_count) >= eff) ? eff - 1 : int'(column_count);
      endfunction

      function bit entry_loaded(int col);
         return loaded[col];
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction

      function void note_request(i8mvz_pkg::cmd_type cmd,
                                 logic signed [i8mvz_pkg::ElemWidth-1:0] value,
                                 logic [i8mvz_pkg::IndexWidth-1:0] index);
         int col;
         int eff_rows;
         int product;
         row_result_type row;
         requests++;
         // vector load stores the element and restarts the matrix
         if (cmd == i8mvz_pkg::CMD_LOAD_VECTOR) begin
            vector_copy[index] = value;
            loaded[index] = 1'b1;
            column_count = '0;
            row_count = '0;
            accumulator = '0;
            loads++;
            return;
         end
         eff_rows = (rows_in_use == 0) ? 1 : int'(rows_in_use);
         col = next_column();
         product = int'(value) * (int'(vector_copy[col]) - int'(zero_point));
         accumulator += product;
         if (col + 1 < effective_cols()) begin
            column_count = i8mvz_pkg::ColsWidth'(col + 1);
            return;
         end
         // row complete
         row.row_sum = accumulator;
         row.row_index = row_count;
         row.last_row = (int'(row_count) + 1 >= eff_rows);
         expected_rows.push_back(row);
         accumulator = '0;
         column_count = '0;
         row_count = row.last_row ? '0 : row_count + 1'b1;
      endfunction

      function void check_result(logic signed [i8mvz_pkg::SumWidth-1:0] sum,
                                 logic [i8mvz_pkg::RowsWidth-1:0] index, logic last);
         row_result_type want;
         results++;
         if (last) last_rows++;
         if (expected_rows.size() == 0) begin
            $error("row result with none expected: row_sum %0d row_index %0d last_row %0b",
                   sum, index, last);
            errors++;
            return;
         end
         want = expected_rows.pop_front();
         if (sum !== want.row_sum) begin
            $error("row_sum expected %0d actual %0d", want.row_sum, sum);
            errors++;
         end
         if (index !== want.row_index) begin
            $error("row_index expected %0d actual %0d", want.row_index, index);
            errors++;
         end
         if (last !== want.last_row) begin
            $error("last_row expected %0b actual %0b", want.last_row, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = i8mvz_pkg::CMD_LOAD_VECTOR;
   logic signed [i8mvz_pkg::ElemWidth-1:0] req_element = '0;
   logic [i8mvz_pkg::IndexWidth-1:0] req_element_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [i8mvz_pkg::SumWidth-1:0] rsp_row_sum;
   logic [i8mvz_pkg::RowsWidth-1:0] rsp_row_index;
   logic rsp_last_row;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = i8mvz_pkg::CSR_ZERO_POINT;
   logic [i8mvz_pkg::CsrWidth-1:0] csr_write_data = '0;

   row_sum_book book = new();
   int send_idle_pct = 10;
   int rsp_idle_pct = 54;
   int settings = 0;

   int8_matrix_vector_zero_point_core #(
      .MAX_COLS(MaxCols)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_element(req_element),
      .req_element_index(req_element_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_row_sum(rsp_row_sum),
      .rsp_row_index(rsp_row_index),
      .rsp_last_row(rsp_last_row),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         book.check_result(rsp_row_sum, rsp_row_index, rsp_last_row);
      end
   end

   // one request, with an optional random gap ahead of it
   task automatic send_request(input i8mvz_pkg::cmd_type cmd,
                               input logic signed [i8mvz_pkg::ElemWidth-1:0] value,
                               input logic [i8mvz_pkg::IndexWidth-1:0] index);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_element <= value;
      req_element_index <= index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(cmd, value, index);
   endtask

   // matrix element; loads the column first if it was never written
   task automatic send_element(input logic signed [i8mvz_pkg::ElemWidth-1:0] value);
      int col;
      col = book.next_column();
      if (!book.entry_loaded(col)) begin
         send_request(i8mvz_pkg::CMD_LOAD_VECTOR, i8mvz_pkg::ElemWidth'($urandom),
                      i8mvz_pkg::IndexWidth'(col));
      end
      send_request(i8mvz_pkg::CMD_MATRIX_ELEMENT, value, i8mvz_pkg::IndexWidth'($urandom));
   endtask

   // hold requests until every row sum is back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index,
                                 input logic [i8mvz_pkg::CsrWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      book.write_register(index, data);
      settings++;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic signed [i8mvz_pkg::ElemWidth-1:0] zp,
                            input logic [i8mvz_pkg::ColsWidth-1:0] cols,
                            input logic [i8mvz_pkg::RowsWidth-1:0] rows);
      settle();
      write_register(i8mvz_pkg::CSR_ZERO_POINT,
                     {{(i8mvz_pkg::CsrWidth-i8mvz_pkg::ElemWidth){zp[i8mvz_pkg::ElemWidth-1]}},
                      zp});
      write_register(i8mvz_pkg::CSR_COLS_IN_USE, i8mvz_pkg::CsrWidth'(cols));
      write_register(i8mvz_pkg::CSR_ROWS_IN_USE, rows);
   endtask

   // element value with extra weight on the extremes
   function automatic logic signed [i8mvz_pkg::ElemWidth-1:0] pick_element();
      case ($urandom_range(0, 7))
         0: return 8'h80;
         1: return 8'h7f;
         default: return i8mvz_pkg::ElemWidth'($urandom);
      endcase
   endfunction

   // load a full vector, then stream matrix rows with occasional stray loads
   task automatic run_segment(input int items);
      int sent;
      int cols;
      cols = book.effective_cols();
      for (int j = 0; j < cols; j++) begin
         send_request(i8mvz_pkg::CMD_LOAD_VECTOR, pick_element(), i8mvz_pkg::IndexWidth'(j));
      end
      sent = cols;
      while (sent < items) begin
         if ($urandom_range(0, 99) < 4) begin
            send_request(i8mvz_pkg::CMD_LOAD_VECTOR, pick_element(),
                         i8mvz_pkg::IndexWidth'($urandom_range(0, 1023)));
         end else begin
            send_element(pick_element());
         end
         sent++;
      end
   endtask

   initial begin
      logic signed [i8mvz_pkg::ElemWidth-1:0] zp;
      logic [i8mvz_pkg::ColsWidth-1:0] cols;
      logic [i8mvz_pkg::RowsWidth-1:0] rows;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: element, index and zero point extremes, two rows of three columns
      configure(8'sd127, 11'd3, 16'd2);
      send_request(i8mvz_pkg::CMD_LOAD_VECTOR, 8'h80, 10'd0);
      send_request(i8mvz_pkg::CMD_LOAD_VECTOR, 8'h7f, 10'd1);
      send_request(i8mvz_pkg::CMD_LOAD_VECTOR, 8'h00, 10'd2);
      send_request(i8mvz_pkg::CMD_LOAD_VECTOR, 8'h55, 10'd1023);
      send_request(i8mvz_pkg::CMD_LOAD_VECTOR, 8'haa, 10'h2aa);
      send_element(8'h80);
      send_element(8'h7f);
      send_element(8'hff);
      send_element(8'h7f);
      send_element(8'h80);
      send_element(8'h00);

      // column counter left past a lowered column limit
      send_element(8'sd5);
      send_element(-8'sd7);
      settle();
      write_register(i8mvz_pkg::CSR_COLS_IN_USE, 16'd1);
      send_element(8'sd3);
      send_element(-8'sd2);

      // row counter left past a lowered row limit, and zero rows acting as one
      send_element(8'sd1);
      settle();
      write_register(i8mvz_pkg::CSR_ROWS_IN_USE, 16'd0);
      send_element(8'sd9);

      // zero columns acting as one, lowest zero point
      settle();
      write_register(i8mvz_pkg::CSR_COLS_IN_USE, 16'd0);
      write_register(i8mvz_pkg::CSR_ZERO_POINT, 16'hff80);
      send_element(8'sd100);
      send_element(-8'sd100);

      // random segments over three idle patterns
      for (int seg = 0; seg < 9; seg++) begin
         zp = i8mvz_pkg::ElemWidth'($urandom);
         cols = ($urandom_range(0, 9) == 0) ? i8mvz_pkg::ColsWidth'($urandom_range(9, 40))
                                            : i8mvz_pkg::ColsWidth'($urandom_range(1, 6));
         rows = i8mvz_pkg::RowsWidth'($urandom_range(1, 4));
         if (seg == 0) zp = 8'h80;
         if (seg == 4) zp = 8'h7f;
         if (seg == 2) rows = 16'hffff;
         if (seg == 5) rows = 16'd0;
         if (seg == 7) cols = 11'd0;
         configure(zp, cols, rows);
         case (seg / 3)
            0: begin
               send_idle_pct = 10;
               rsp_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               rsp_idle_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         run_segment(SegmentItems);
      end

      // drain and report
      settle();
      repeat (2 * SettleCycles) @(posedge clock);
      $display("covered %0d requests (%0d vector loads) and %0d row sums (%0d last rows)",
               book.requests, book.loads, book.results, book.last_rows);
      $display("over %0d register writes across three idle patterns", settings);
      if (book.errors == 0) begin
         $display("** int8_matrix_vector_zero_point_core: PASSED **");
      end else begin
         $display("** int8_matrix_vector_zero_point_core: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("** int8_matrix_vector_zero_point_core: FAILED **");
      $finish;
   end

endmodule
